// ===== sv/butterworth_band_reject_mask_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Butterworth band-reject mask generator
// Concurrent checks on the rising clock edge, switched off while reset is low.
// ----------------------------------------------------------------------------
`ifndef BUTTERWORTH_BAND_REJECT_MASK_MACROS_SVH
`define BUTTERWORTH_BAND_REJECT_MASK_MACROS_SVH

`ifndef SYNTH
`define BRR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define BRR_ASSERT(lbl, prop, msg)
`define BRR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/brr_pkg.sv =====
// ----------------------------------------------------------------------------
// Butterworth band-reject mask package
// Widths, reset values, register codes and the side-band type of the pipeline.
// ----------------------------------------------------------------------------
package brr_pkg;

	localparam int MAX_DIM             = 1024;
	localparam int GAIN_FRAC_BITS_DEF  = 15;

	localparam int COORD_W    = 10;
	localparam int DIM_W      = 11;
	localparam int RAD_W      = 10;
	localparam int ORD_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int IN_TDATA_W = 24;
	localparam int GAIN_W     = 16;

	localparam int SQ_W    = 2 * COORD_W;   // one squared distance
	localparam int R2_W    = SQ_W + 1;      // sum of two squares
	localparam int PQ_W    = 2 * R2_W;      // p and q
	localparam int RATIO_W = 17;            // 0 .. 65536
	localparam int FRAC_W  = 16;

	localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;
	localparam logic [GAIN_W-1:0]  GAIN_MAX  = 16'hFFFF;

	localparam logic [DIM_W-1:0] ROWS_RST   = 11'd1024;
	localparam logic [DIM_W-1:0] COLS_RST   = 11'd1024;
	localparam logic [RAD_W-1:0] RADIUS_RST = 10'd20;
	localparam logic [RAD_W-1:0] WIDTH_RST  = 10'd3;
	localparam logic [ORD_W-1:0] ORDER_RST  = 4'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS   = 3'd0,
		REG_COLS   = 3'd1,
		REG_RADIUS = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_ORDER  = 3'd4
	} cfg_reg_t;

	// Flags that travel with every item alongside the arithmetic.
	typedef struct packed {
		logic             ord0;   // order zero, gain is one half
		logic             both0;  // p and q both zero, gain is one
		logic             qlep;   // q <= p
		logic [ORD_W-1:0] n;
	} item_flags_t;

endpackage

// ===== sv/brr_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, most significant first. The dividend
// must be below den * 2^QW; a side band travels alongside each item.
// ----------------------------------------------------------------------------
module brr_div #(
	parameter int QW = 17,
	parameter int VW = 42,
	parameter int SW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [VW+QW-1:0] in_x,
	input  logic [VW-1:0]    in_den,
	input  logic [SW-1:0]    in_side,
	output logic             out_valid,
	output logic [QW-1:0]    out_quo,
	output logic [SW-1:0]    out_side
);
	localparam int XW = VW + QW;

	logic          v_s    [QW];
	logic [XW-1:0] x_s    [QW];
	logic [VW-1:0] den_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic          pv;
		logic [XW-1:0] px;
		logic [XW-1:0] sh;
		logic [VW-1:0] pd;
		logic [QW-1:0] pq;
		logic [SW-1:0] ps;
		logic          ge;

		if (k == 0) begin : g_first
			assign pv = in_valid;
			assign px = in_x;
			assign pd = in_den;
			assign pq = '0;
			assign ps = in_side;
		end else begin : g_next
			assign pv = v_s[k-1];
			assign px = x_s[k-1];
			assign pd = den_s[k-1];
			assign pq = quo_s[k-1];
			assign ps = side_s[k-1];
		end

		assign sh = XW'(pd) << B;
		assign ge = (px >= sh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= ge ? px - sh : px;
				den_s[k]  <= pd;
				side_s[k] <= ps;
				quo_s[k]  <= pq | (QW'(ge) << B);
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

// ===== sv/butterworth_band_reject_mask.sv =====
// Path: stages 1 to 6, the ratio divider, the power chain, stage 7, the gain divider, the output register.
// Throughput: one coordinate per cycle while the skid entry is empty; the whole pipeline advances together.
// The two dividers (one quotient bit per stage) and the power chain set the depth.
// A two-entry output register absorbs a stall; input ready falls only when both are full.
// Reset (asynchronous, active low) clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// Butterworth band-reject mask generator
// Maps a frequency-plane coordinate to the band-reject gain in Q1.GAIN_FRAC_BITS.
// ----------------------------------------------------------------------------
`include "butterworth_band_reject_mask_macros.svh"

module butterworth_band_reject_mask #(
	parameter int GAIN_FRAC_BITS = brr_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [9:0] row_index, [19:10] col_index, [23:20] zero
	input  logic [brr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [15:0] gain
	output logic [brr_pkg::GAIN_W-1:0]       m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [brr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [brr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import brr_pkg::*;

	localparam int X1_W  = PQ_W + RATIO_W;
	localparam int PSTG  = (2 ** ORD_W) - 1;
	localparam int GQW   = GAIN_FRAC_BITS + 1;
	localparam int GVW   = RATIO_W + 1;
	localparam int GXW   = GVW + GQW;
	localparam int PROD_W = 2 * RATIO_W;
	localparam int EXT_W = GQW + GAIN_W;
	localparam int FW    = $bits(item_flags_t);

	localparam logic [63:0] HALF_FULL = 64'd1 << (GAIN_FRAC_BITS - 1);
	localparam logic [63:0] UNIT_FULL = 64'd1 << GAIN_FRAC_BITS;
	localparam logic [GAIN_W-1:0] GAIN_HALF = HALF_FULL[GAIN_W-1:0];
	localparam logic [GAIN_W-1:0] GAIN_UNIT =
		(UNIT_FULL > 64'(GAIN_MAX)) ? GAIN_MAX : UNIT_FULL[GAIN_W-1:0];

	// Configuration registers
	logic [DIM_W-1:0] rows_q, cols_q;
	logic [RAD_W-1:0] radius_q, width_q;
	logic [ORD_W-1:0] order_q;
	logic [SQ_W-1:0]  d2_q, w2_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ROWS_RST;
			cols_q   <= COLS_RST;
			radius_q <= RADIUS_RST;
			width_q  <= WIDTH_RST;
			order_q  <= ORDER_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROWS:   rows_q   <= cfg_data;
				REG_COLS:   cols_q   <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[RAD_W-1:0];
				REG_ORDER:  order_q  <= cfg_data[ORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Squares of the band parameters are registered and follow the registers in the next cycle.
	always_ff @(posedge clk) begin
		d2_q <= radius_q * radius_q;
		w2_q <= width_q * width_q;
	end

	// Pipeline control
	logic en;
	logic skid_v_q, out_v_q;
	logic [GAIN_W-1:0] skid_g_q, out_g_q;

	assign en            = ~skid_v_q;
	assign s_axis_tready = en;

	// Stage 1: distances from the centre
	logic [DIM_W-1:0]   rows_c, cols_c;
	logic [COORD_W-1:0] cen_r, cen_c, in_row, in_col, dr, dc;

	assign rows_c = (rows_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_q;
	assign cols_c = (cols_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_q;
	assign cen_r  = rows_c[DIM_W-1:1];
	assign cen_c  = cols_c[DIM_W-1:1];
	assign in_row = s_axis_tdata[COORD_W-1:0];
	assign in_col = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign dr     = (in_row >= cen_r) ? in_row - cen_r : cen_r - in_row;
	assign dc     = (in_col >= cen_c) ? in_col - cen_c : cen_c - in_col;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [COORD_W-1:0] dr_s1, dc_s1;
	logic [SQ_W-1:0]    sqr_s2, sqc_s2;
	logic [R2_W-1:0]    r2_s3, r2_s4, diff_s4;
	logic [PQ_W-1:0]    q_s5, p_s5;
	logic [X1_W-1:0]    x_s6;
	logic [PQ_W-1:0]    den_s6;
	logic [ORD_W-1:0]   n_s1, n_s2, n_s3, n_s4, n_s5;
	item_flags_t        f_s6, f_s7;
	logic [GXW-1:0]     x_s7;
	logic [GVW-1:0]     d_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 6 selects the smaller of p and q as numerator, rounding added up front.
	logic        qlep;
	logic [PQ_W-1:0] num6, den6;

	assign qlep = (q_s5 <= p_s5);
	assign num6 = qlep ? q_s5 : p_s5;
	assign den6 = qlep ? p_s5 : q_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s1   <= dr;
			dc_s1   <= dc;
			n_s1    <= order_q;
			sqr_s2  <= dr_s1 * dr_s1;
			sqc_s2  <= dc_s1 * dc_s1;
			n_s2    <= n_s1;
			r2_s3   <= R2_W'(sqr_s2) + R2_W'(sqc_s2);
			n_s3    <= n_s2;
			r2_s4   <= r2_s3;
			diff_s4 <= (r2_s3 >= R2_W'(d2_q)) ? r2_s3 - R2_W'(d2_q) : R2_W'(d2_q) - r2_s3;
			n_s4    <= n_s3;
			q_s5    <= PQ_W'(r2_s4) * PQ_W'(w2_q);
			p_s5    <= diff_s4 * diff_s4;
			n_s5    <= n_s4;
			x_s6    <= (X1_W'(num6) << FRAC_W) + X1_W'(den6 >> 1);
			den_s6  <= den6;
			f_s6    <= '{ord0: (n_s5 == '0), both0: (p_s5 == '0) && (q_s5 == '0),
				     qlep: qlep, n: n_s5};
		end
	end

	// Ratio of the smaller to the larger square, Q1.16
	logic               rv_d;
	logic [RATIO_W-1:0] ratio_d;
	logic [FW-1:0]      rside_d;
	item_flags_t        rf_d;

	brr_div #(.QW(RATIO_W), .VW(PQ_W), .SW(FW)) u_ratio_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_x      (x_s6),
		.in_den    (den_s6),
		.in_side   (f_s6),
		.out_valid (rv_d),
		.out_quo   (ratio_d),
		.out_side  (rside_d)
	);

	assign rf_d = item_flags_t'(rside_d);

	// Power chain: stage i multiplies once when i is below the order.
	logic               pv_s [PSTG];
	logic [RATIO_W-1:0] ps_s [PSTG];
	logic [RATIO_W-1:0] pr_s [PSTG];
	item_flags_t        pf_s [PSTG];

	for (genvar i = 0; i < PSTG; i++) begin : g_pow
		logic               prv_v;
		logic [RATIO_W-1:0] prv_s, prv_r;
		item_flags_t        prv_f;
		logic [PROD_W-1:0]  prod;

		if (i == 0) begin : g_first
			assign prv_v = rv_d;
			assign prv_s = RATIO_ONE;
			assign prv_r = ratio_d;
			assign prv_f = rf_d;
		end else begin : g_next
			assign prv_v = pv_s[i-1];
			assign prv_s = ps_s[i-1];
			assign prv_r = pr_s[i-1];
			assign prv_f = pf_s[i-1];
		end

		assign prod = (prv_s * prv_r) + PROD_W'(32768);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv_s[i] <= 1'b0;
			end else if (en) begin
				pv_s[i] <= prv_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ps_s[i] <= (ORD_W'(i) < prv_f.n) ? prod[FRAC_W+RATIO_W-1:FRAC_W] : prv_s;
				pr_s[i] <= prv_r;
				pf_s[i] <= prv_f;
			end
		end
	end

	// Stage 7: gain numerator and denominator 1 + s
	logic [RATIO_W-1:0] s_fin, num7;
	logic [GVW-1:0]     d7;

	assign s_fin = ps_s[PSTG-1];
	assign num7  = pf_s[PSTG-1].qlep ? RATIO_ONE : s_fin;
	assign d7    = GVW'(RATIO_ONE) + GVW'(s_fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= pv_s[PSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s7 <= (GXW'(num7) << GAIN_FRAC_BITS) + GXW'(d7 >> 1);
			d_s7 <= d7;
			f_s7 <= pf_s[PSTG-1];
		end
	end

	logic           gv_d;
	logic [GQW-1:0] gq_d;
	logic [FW-1:0]  gside_d;
	item_flags_t    gf_d;

	brr_div #(.QW(GQW), .VW(GVW), .SW(FW)) u_gain_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_x      (x_s7),
		.in_den    (d_s7),
		.in_side   (f_s7),
		.out_valid (gv_d),
		.out_quo   (gq_d),
		.out_side  (gside_d)
	);

	assign gf_d = item_flags_t'(gside_d);

	// Saturation and the special cases
	logic [EXT_W-1:0]  gq_ext;
	logic [GAIN_W-1:0] g_sat, g_res;
	logic              incoming, pop;

	assign gq_ext = EXT_W'(gq_d);
	assign g_sat  = (gq_ext > EXT_W'(GAIN_MAX)) ? GAIN_MAX : gq_ext[GAIN_W-1:0];
	assign g_res  = gf_d.ord0 ? GAIN_HALF : (gf_d.both0 ? GAIN_UNIT : g_sat);

	assign incoming = en & gv_d;
	assign pop      = out_v_q & m_axis_tready;

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || pop) begin
			out_v_q <= incoming;
		end else if (incoming) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_g_q <= skid_g_q;
			end
		end else if (!out_v_q || pop) begin
			out_g_q <= g_res;
		end else begin
			skid_g_q <= g_res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_g_q;

	`BRR_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "skid entry full while output empty")
	`BRR_ASSERT(a_skid_fill, $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready), "early skid fill")
	`BRR_ASSERT(a_gain_bound, out_v_q |-> (out_g_q <= GAIN_UNIT), "gain above unity")
	`BRR_ASSERT(a_ratio_bound, (rv_d && !rf_d.both0) |-> (ratio_d <= RATIO_ONE), "ratio above one")
	`BRR_ASSERT_NEXT(a_stall_holds, skid_v_q && !m_axis_tready, skid_v_q && !s_axis_tready, "skid lost")

endmodule

// ===== tb/sv/butterworth_band_reject_mask_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Band-reject gain checker
// Watches the configuration, coordinate and gain channels, keeps its own copy
// of the registers, computes the gain for every accepted coordinate and
// compares each gain transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module butterworth_band_reject_mask_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	// [9:0] row_index, [19:10] col_index, [23:20] zero
	input  logic [brr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [15:0] gain
	input  logic [brr_pkg::GAIN_W-1:0]       m_axis_tdata,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [brr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [brr_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                               fail_count,
	output int                               gains_pending
);
	import brr_pkg::*;

	logic [DIM_W-1:0] plane_rows, plane_cols;
	logic [RAD_W-1:0] band_radius, band_wid;
	logic [ORD_W-1:0] order_n;
	logic [GAIN_W-1:0] gain_queue[$];

	assign gains_pending = gain_queue.size();

	function automatic longint unsigned centre_sq(longint unsigned coord, longint unsigned size);
		longint unsigned c, d;
		c = (size > MAX_DIM ? MAX_DIM : size) / 2;
		d = coord >= c ? coord - c : c - coord;
		return d * d;
	endfunction

	function automatic logic [GAIN_W-1:0] band_gain(logic [COORD_W-1:0] row,
			logic [COORD_W-1:0] col);
		longint unsigned r2, d2, diff, q, p, num, den, ratio, s, d, g, one;
		one = longint'(1) << GAIN_FRAC_BITS_DEF;
		r2 = centre_sq(row, plane_rows) + centre_sq(col, plane_cols);
		d2 = longint'(band_radius) * band_radius;
		diff = r2 >= d2 ? r2 - d2 : d2 - r2;
		q = r2 * band_wid * band_wid;
		p = diff * diff;
		if (order_n == 0)
			return GAIN_W'(one / 2);
		if (p == 0 && q == 0)
			return one > GAIN_MAX ? GAIN_MAX : GAIN_W'(one);
		num = q <= p ? q : p;
		den = q <= p ? p : q;
		ratio = (num * 65536 + den / 2) / den;
		s = 65536;
		for (int i = 0; i < order_n; i++)
			s = (s * ratio + 32768) >> 16;
		d = 65536 + s;
		// Where q <= p the gain is 1/(1+s), otherwise s/(1+s).
		g = (one * (q <= p ? 65536 : s) + d / 2) / d;
		return g > GAIN_MAX ? GAIN_MAX : GAIN_W'(g);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [GAIN_W-1:0] want;
		if (!arst_n) begin
			plane_rows  <= ROWS_RST;
			plane_cols  <= COLS_RST;
			band_radius <= RADIUS_RST;
			band_wid    <= WIDTH_RST;
			order_n     <= ORDER_RST;
			gain_queue.delete();
			fail_count  <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (gain_queue.size() == 0) begin
					$error("gain transfer with nothing outstanding: actual %0d", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = gain_queue.pop_front();
					if (m_axis_tdata !== want) begin
						$error("gain: expected %0d, actual %0d", want, m_axis_tdata);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				gain_queue.push_back(band_gain(s_axis_tdata[COORD_W-1:0],
					s_axis_tdata[2*COORD_W-1:COORD_W]));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROWS:   plane_rows  <= cfg_data[DIM_W-1:0];
					REG_COLS:   plane_cols  <= cfg_data[DIM_W-1:0];
					REG_RADIUS: band_radius <= cfg_data[RAD_W-1:0];
					REG_WIDTH:  band_wid    <= cfg_data[RAD_W-1:0];
					REG_ORDER:  order_n     <= cfg_data[ORD_W-1:0];
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== tb/sv/butterworth_band_reject_mask_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Band-reject mask generator testbench
// Drives coordinates with random gaps against random output stalls, writes the
// registers between runs, walks through several filter settings including the
// extremes, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module butterworth_band_reject_mask_tb;
	import brr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
	localparam int DRAIN_CYCLES = 70;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic [GAIN_W-1:0] m_axis_tdata;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count, gains_pending;

	bit steady_flow;     // no idling on either side while set
	bit long_hold_req;
	int centre_row, centre_col, ring_radius, ring_width;

	butterworth_band_reject_mask dut (.*);
	butterworth_band_reject_mask_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[butterworth_band_reject_mask] ERROR");
		$finish;
	end

	function automatic int idle_len();
		int roll;
		roll = $urandom_range(99);
		if (steady_flow || roll < 70)
			return 0;
		return roll < 95 ? $urandom_range(3, 1) : $urandom_range(40, 10);
	endfunction

	// Output side: random back-pressure plus one long hold-off on request.
	initial begin
		int k;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				m_axis_tready <= 0;
				for (k = 0; k < 400; k++)
					@(posedge clk);
				long_hold_req = 0;
			end
			m_axis_tready <= 1;
			@(posedge clk);
			k = idle_len();
			if (k > 0) begin
				m_axis_tready <= 0;
				repeat (k) @(posedge clk);
			end
		end
	end

	task automatic send_coord(int row, int col);
		int gap;
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'b0, 10'(col), 10'(row)};
		do @(posedge clk); while (!s_axis_tready);
		gap = idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (gains_pending != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_filter(int rows, int cols, int rad, int wid, int ord);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		reg_write(REG_ROWS, rows);
		reg_write(REG_COLS, cols);
		reg_write(REG_RADIUS, rad);
		reg_write(REG_WIDTH, wid);
		reg_write(REG_ORDER, ord);
		cfg_valid <= 0;
		centre_row = (rows > MAX_DIM ? MAX_DIM : rows) / 2;
		centre_col = (cols > MAX_DIM ? MAX_DIM : cols) / 2;
		ring_radius = rad;
		ring_width = wid;
	endtask

	// Most coordinates land near the rejected ring, where the gain moves.
	task automatic random_coords(int count);
		int row, col, reach;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 7) begin
				reach = ring_radius + ring_width + 2;
				row = centre_row + $urandom_range(2 * reach) - reach;
				col = centre_col + $urandom_range(2 * reach) - reach;
				row = row < 0 ? 0 : (row > 1023 ? 1023 : row);
				col = col < 0 ? 0 : (col > 1023 ? 1023 : col);
			end else begin
				row = $urandom_range(1023);
				col = $urandom_range(1023);
			end
			send_coord(row, col);
		end
	endtask

	initial begin
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		cfg_valid = 0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		centre_row = 512;
		centre_col = 512;
		ring_radius = 20;
		ring_width = 3;
		steady_flow = 0;
		long_hold_req = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Defaults: corners, the centre, and points on and near the ring.
		send_coord(0, 0);
		send_coord(1023, 1023);
		send_coord(0, 1023);
		send_coord(512, 512);
		send_coord(532, 512);
		send_coord(512, 492);
		send_coord(540, 520);
		// An unknown register index must leave everything as it was.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		reg_write(REG_UNUSED, 2047);
		cfg_valid <= 0;
		send_coord(532, 512);
		send_coord(700, 300);
		// Zero radius and width make p and q vanish together at the centre.
		set_filter(1024, 1024, 0, 0, 3);
		send_coord(512, 512);
		send_coord(513, 512);
		set_filter(1024, 1024, 0, 5, 1);
		send_coord(512, 512);
		send_coord(600, 400);
		// Order zero gives one half everywhere.
		set_filter(1024, 1024, 0, 0, 0);
		send_coord(512, 512);
		send_coord(100, 900);
		// Oversize plane behaves as the largest one.
		set_filter(2047, 2047, 10, 4, 2);
		send_coord(512, 522);
		send_coord(1023, 0);

		set_filter(1024, 1024, 20, 3, 2);
		long_hold_req = 1;
		random_coords(200);
		wait_drained();
		steady_flow = 1;
		random_coords(150);
		steady_flow = 0;
		set_filter(2, 2, 0, 0, 1);
		random_coords(120);
		set_filter(2047, 2047, 512, 512, 10);
		random_coords(150);
		set_filter(1024, 1024, 0, 512, 15);
		random_coords(150);
		set_filter(100, 37, 30, 5, 3);
		random_coords(150);
		set_filter(1023, 2, 512, 1, 10);
		random_coords(120);
		for (int ph = 0; ph < 4; ph++) begin
			set_filter($urandom_range(2047, 2), $urandom_range(2047, 2), $urandom_range(1023),
				$urandom_range(1023), $urandom_range(15));
			random_coords(90);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[butterworth_band_reject_mask] OK");
		else
			$display("[butterworth_band_reject_mask] ERROR");
		$finish;
	end
endmodule
